/* rtl/crc8ftr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8ftr_pkg
// Shared constants, types and the byte-wide crc-8 step for the receiver.
// ----------------------------------------------------------------------------
package crc8ftr_pkg;

   localparam int TELEMETRY_BYTES = 19;
   localparam int STORE_IDX_W     = $clog2(TELEMETRY_BYTES);
   localparam int FRAME_W         = 8 * TELEMETRY_BYTES;

   // result bus: four tick words, sensor bits, battery, zero fill to bytes
   localparam int TICK_W     = 32;
   localparam int LINE_W     = 5;
   localparam int BATT_W     = 16;
   localparam int RSP_USED_W = 4 * TICK_W + LINE_W + BATT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [7:0] CRC_POLY      = 8'h07;
   localparam logic [7:0] HEADER_RESET  = 8'hAA;
   localparam logic [7:0] MAX_LEN_RESET = 8'd64;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 1'b1;

   typedef logic [FRAME_W-1:0] frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // msb-first crc-8 update over one byte, no reflection
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/crc8ftr_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8ftr_parser
// Front end: frame hunt, length check, payload capture and crc check.
// ----------------------------------------------------------------------------
module crc8ftr_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [crc8ftr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                            csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  crc8ftr_pkg::queue_status_type         q_status,
   output logic                                  q_push,
   output crc8ftr_pkg::frame_type                q_frame
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] header_ff;
   logic [7:0] max_len_ff;
   logic [7:0] len_ff, len_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] store_ff [crc8ftr_pkg::TELEMETRY_BYTES];
   logic       accept;
   logic       store_we;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign store_we   = accept && (phase_ff == PH_PAYLOAD)
                       && (count_ff < 8'(crc8ftr_pkg::TELEMETRY_BYTES));

   assign q_push = accept && (phase_ff == PH_CRC) && (req_tdata == crc_ff)
                   && (len_ff == 8'(crc8ftr_pkg::TELEMETRY_BYTES));

   always_comb begin
      for (int k = 0; k < crc8ftr_pkg::TELEMETRY_BYTES; k++) begin
         q_frame[8*k +: 8] = store_ff[k];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_tdata == header_ff) begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               len_in = req_tdata;
               if (req_tdata == 8'd0 || req_tdata > max_len_ff) begin
                  phase_in = PH_HUNT;
               end else begin
                  count_in = 8'd0;
                  crc_in   = 8'd0;
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in   = crc8ftr_pkg::crc8_next(crc_ff, req_tdata);
               count_in = count_ff + 8'd1;
               if (count_in >= len_ff) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         len_ff     <= 8'd0;
         count_ff   <= 8'd0;
         crc_ff     <= 8'd0;
         header_ff  <= crc8ftr_pkg::HEADER_RESET;
         max_len_ff <= crc8ftr_pkg::MAX_LEN_RESET;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         if (csr_we) begin
            unique case (csr_index)
               crc8ftr_pkg::CSR_HEADER_BYTE: header_ff  <= csr_data;
               crc8ftr_pkg::CSR_MAX_PAYLOAD: max_len_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload capture, undefined until the first frame fills it
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff[crc8ftr_pkg::STORE_IDX_W-1:0]] <= req_tdata;
      end
   end

   // a payload phase always has a nonzero length and a byte count below that length
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (len_ff != 8'd0 && count_ff < len_ff))
      else $error("payload count ran past frame length");

endmodule

/* rtl/crc8ftr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8ftr_fifo
// Two-entry queue of checked frames between the parser and the output stage.
// ----------------------------------------------------------------------------
module crc8ftr_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  crc8ftr_pkg::frame_type         push_frame,
   input  logic                           pop,
   output crc8ftr_pkg::frame_type         pop_frame,
   output crc8ftr_pkg::queue_status_type  status
);

   crc8ftr_pkg::frame_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_frame    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");

   assert property (@(posedge clock) disable iff (reset) !(push && status.full))
      else $error("push into full queue");

endmodule

/* rtl/crc8ftr_unpack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8ftr_unpack
// Back end: splits a stored frame into result fields and holds the result.
// ----------------------------------------------------------------------------
module crc8ftr_unpack (
   input  logic                                   clock,
   input  logic                                   reset,
   input  crc8ftr_pkg::queue_status_type          q_status,
   input  crc8ftr_pkg::frame_type                 q_frame,
   output logic                                   q_pop,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [crc8ftr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int TICKS_W = 4 * crc8ftr_pkg::TICK_W;
   localparam int PAD_W   = crc8ftr_pkg::RSP_DATA_W - crc8ftr_pkg::RSP_USED_W;

   logic                                valid_ff, valid_in;
   logic [crc8ftr_pkg::RSP_DATA_W-1:0]  data_ff, data_in;

   assign q_pop = !q_status.empty && (!valid_ff || rsp_tready);

   // payload bytes are already little-endian in place; sensor byte is trimmed
   always_comb begin
      data_in = {PAD_W'(0),
                 q_frame[8*17 +: crc8ftr_pkg::BATT_W],
                 q_frame[8*16 +: crc8ftr_pkg::LINE_W],
                 q_frame[TICKS_W-1:0]};
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !q_pop)
      else $error("result overwritten while stalled");

endmodule

/* rtl/crc8_framed_telemetry_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_telemetry_receiver
// Header / length / payload / crc-8 frame parser for wheel telemetry.
//
// Takes one received byte per cycle on req_ while the two-entry frame queue
// has room; req_tready drops only when two checked frames wait behind a
// stalled rsp_ side. A frame of 19 payload bytes whose crc-8 (poly 0x07,
// init 0) matches the trailing byte yields one result, which reaches rsp_
// through the queue write and then the output register, where it is held
// while rsp_ stalls. All other frames are dropped silently.
// Configuration writes (header byte, maximum payload length) take effect at
// the next clock edge and should be made while no frame is in flight.
// ----------------------------------------------------------------------------
module crc8_framed_telemetry_receiver (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [crc8ftr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                            csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] rx_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] tick_front_left, [63:32] tick_front_right, [95:64] tick_rear_left,
   // [127:96] tick_rear_right, [132:128] line_sensors, [148:133] battery_level
   output logic [crc8ftr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   crc8ftr_pkg::queue_status_type q_status;
   crc8ftr_pkg::frame_type        push_frame;
   crc8ftr_pkg::frame_type        pop_frame;
   logic                          q_push;
   logic                          q_pop;

   crc8ftr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_frame    (push_frame)
   );

   crc8ftr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (push_frame),
      .pop        (q_pop),
      .pop_frame  (pop_frame),
      .status     (q_status)
   );

   crc8ftr_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_frame    (pop_frame),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
